// ===== design/nsfc_pkg.sv =====
// Package for the sentence framer and checksum checker.
// Holds character codes, status and type codes, the result word and helpers.
// No dependencies.
`timescale 1ns / 1ps

package nsfc_pkg;

  localparam int SentenceCapDef = 128;

  localparam logic [7:0] ChrDollar = 8'h24;
  localparam logic [7:0] ChrStar   = 8'h2A;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrTilde  = 8'h7E;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrLf     = 8'h0A;

  localparam logic [23:0] TagGga = {8'h47, 8'h47, 8'h41};
  localparam logic [23:0] TagRmc = {8'h52, 8'h4D, 8'h43};
  localparam logic [23:0] TagVtg = {8'h56, 8'h54, 8'h47};
  localparam logic [23:0] TagGsa = {8'h47, 8'h53, 8'h41};

  localparam int ResultW = 44;
  localparam int OutDataW = 48;

  typedef enum logic [1:0] {
    ST_GOOD_KNOWN,
    ST_GOOD_UNKNOWN,
    ST_BAD_SUM,
    ST_NO_STAR
  } nsfc_status_e;

  typedef enum logic [2:0] {
    TY_GGA,
    TY_RMC,
    TY_VTG,
    TY_GSA,
    TY_OTHER
  } nsfc_type_e;

  // Last member sits in the lowest bits, so status lands at bit 0.
  typedef struct packed {
    logic [15:0]  good_count;
    logic [6:0]   sentence_length;
    logic [7:0]   received_sum;
    logic [7:0]   computed_sum;
    nsfc_type_e   sentence_type;
    nsfc_status_e status;
  } nsfc_result_t;

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic nsfc_type_e match_type(logic [23:0] tag);
    nsfc_type_e t;
    case (tag)
      TagGga:  t = TY_GGA;
      TagRmc:  t = TY_RMC;
      TagVtg:  t = TY_VTG;
      TagGsa:  t = TY_GSA;
      default: t = TY_OTHER;
    endcase
    return t;
  endfunction

endpackage

// ===== design/nmea_sentence_framer_checker_top.sv =====
// Top level of the sentence framer and checksum checker.
// Depends on nsfc_pkg, nsfc_in_reg, nsfc_core and nsfc_out_reg.
//
// Usage:
//   The slave stream takes one received byte per word on s_axis_tdata.
//   Bytes outside printable ASCII, CR and LF are dropped. '$' opens a
//   sentence; CR or LF closes it and emits one result word on the master
//   stream. A sentence that reaches the size limit is dropped silently.
//   A terminator byte is held in the input register, decoded by the core
//   combinationally and loaded into the result register, which takes the
//   result word only while that register is free.
//   Throughput: one byte per cycle while the master side takes each result
//   word as soon as it is offered.
//   A stalled master side holds the result word and stops the core; the
//   input register takes a byte only while it is empty, then s_axis_tready drops
//   until the waiting result word is taken.
//   Reset clears the sentence state, the good-sentence count and both
//   registers' valid flags; no result is pending after reset.
`timescale 1ns / 1ps

module nmea_sentence_framer_checker_top #(
  parameter int SentenceCap = nsfc_pkg::SentenceCapDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] status, [4:2] sentence_type, [12:5] computed_sum,
  // [20:13] received_sum, [27:21] sentence_length, [43:28] good_count, rest zero
  output logic [nsfc_pkg::OutDataW-1:0] m_axis_tdata
);
  import nsfc_pkg::*;

  logic         held_valid;
  logic [7:0]   held_byte;
  logic         out_free;
  logic         step;
  logic         res_valid;
  nsfc_result_t res;
  nsfc_result_t res_out;

  assign step = held_valid && out_free;

  nsfc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .take_i     (step),
    .valid_o    (held_valid),
    .byte_o     (held_byte)
  );

  nsfc_core #(
    .SentenceCap (SentenceCap)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nsfc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {(OutDataW - ResultW)'(0), res_out};

`ifndef NO_ASSERTIONS
  a_known_type_on_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_out.status == ST_GOOD_KNOWN) |-> res_out.sentence_type != TY_OTHER)
    else $error("good known sentence reported with other type");

  a_no_star_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_out.status == ST_NO_STAR) |-> res_out.received_sum == 8'h00)
    else $error("received sum nonzero without asterisk");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid)
    else $error("core result not captured in result register");
`endif

endmodule

// ===== design/nsfc_in_reg.sv =====
// Input register for received bytes.
// Holds one word until the core takes it; depends on nothing else.
`timescale 1ns / 1ps

module nsfc_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // A new word may enter while the held one leaves in the same cycle.
  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

// ===== design/nsfc_core.sv =====
// Sentence state and per-byte update: framing, XOR sum, hex checksum, type tag.
// Depends on nsfc_pkg.
`timescale 1ns / 1ps

module nsfc_core #(
  parameter int SentenceCap = nsfc_pkg::SentenceCapDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  res_valid_o,
  output nsfc_pkg::nsfc_result_t res_o
);
  import nsfc_pkg::*;

  localparam int CntW = $clog2(SentenceCap);
  localparam logic [CntW-1:0] LastPos = CntW'(SentenceCap - 1);
  localparam logic [CntW-1:0] Pos1 = CntW'(1);
  localparam logic [CntW-1:0] Pos3 = CntW'(3);
  localparam logic [CntW-1:0] Pos4 = CntW'(4);
  localparam logic [CntW-1:0] Pos5 = CntW'(5);
  localparam logic [CntW-1:0] Pos6 = CntW'(6);

  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      xor_q, xor_d;
  logic            star_q, star_d;
  logic            hex_open_q, hex_open_d;
  logic [7:0]      hex_q, hex_d;
  logic [23:0]     tag_q, tag_d;
  logic [15:0]     total_q, total_d;

  logic             accepted;
  logic             is_term;
  logic [4:0]       hd;
  nsfc_type_e       stype;
  nsfc_status_e     status;
  logic [15:0]      total_inc;
  logic [CntW+6:0]  len_wide;

  assign is_term  = (byte_i == ChrCr) || (byte_i == ChrLf);
  assign accepted = (byte_i >= ChrSpace && byte_i <= ChrTilde) || is_term;
  assign hd       = hex_digit(byte_i);

  always_comb begin
    stype = (cnt_q >= Pos6) ? match_type(tag_q) : TY_OTHER;
    if (!star_q) begin
      status = ST_NO_STAR;
    end else if (xor_q != hex_q) begin
      status = ST_BAD_SUM;
    end else if (stype != TY_OTHER) begin
      status = ST_GOOD_KNOWN;
    end else begin
      status = ST_GOOD_UNKNOWN;
    end
  end

  assign total_inc = total_q + 16'd1;
  assign len_wide  = {7'd0, cnt_q};

  always_comb begin
    res_o.status          = status;
    res_o.sentence_type   = stype;
    res_o.computed_sum    = xor_q;
    res_o.received_sum    = star_q ? hex_q : 8'h00;
    res_o.sentence_length = len_wide[6:0];
    res_o.good_count      = (status == ST_GOOD_KNOWN) ? total_inc : total_q;
  end

  always_comb begin
    in_frame_d  = in_frame_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    star_d      = star_q;
    hex_open_d  = hex_open_q;
    hex_d       = hex_q;
    tag_d       = tag_q;
    total_d     = total_q;
    res_valid_o = 1'b0;

    if (step_i && accepted) begin
      if (byte_i == ChrDollar) begin
        in_frame_d = 1'b1;
        cnt_d      = Pos1;
        xor_d      = 8'h00;
        star_d     = 1'b0;
        hex_open_d = 1'b0;
        hex_d      = 8'h00;
        tag_d      = 24'h0;
      end else if (in_frame_q) begin
        if (is_term || cnt_q >= LastPos) begin
          // Terminator reports the sentence; hitting the size limit drops it.
          res_valid_o = is_term;
          if (is_term) begin
            total_d = res_o.good_count;
          end
          in_frame_d = 1'b0;
          cnt_d      = '0;
          xor_d      = 8'h00;
          star_d     = 1'b0;
          hex_open_d = 1'b0;
          hex_d      = 8'h00;
          tag_d      = 24'h0;
        end else begin
          if (cnt_q == Pos3) begin
            tag_d[23:16] = byte_i;
          end else if (cnt_q == Pos4) begin
            tag_d[15:8] = byte_i;
          end else if (cnt_q == Pos5) begin
            tag_d[7:0] = byte_i;
          end
          if (!star_q) begin
            if (byte_i == ChrStar) begin
              star_d     = 1'b1;
              hex_open_d = 1'b1;
            end else begin
              xor_d = xor_q ^ byte_i;
            end
          end else if (hex_open_q) begin
            if (!hd[4]) begin
              hex_open_d = 1'b0;
            end else begin
              hex_d = {hex_q[3:0], hd[3:0]};
            end
          end
          cnt_d = cnt_q + Pos1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      xor_q      <= 8'h00;
      star_q     <= 1'b0;
      hex_open_q <= 1'b0;
      hex_q      <= 8'h00;
      tag_q      <= 24'h0;
      total_q    <= 16'h0;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      xor_q      <= xor_d;
      star_q     <= star_d;
      hex_open_q <= hex_open_d;
      hex_q      <= hex_d;
      tag_q      <= tag_d;
      total_q    <= total_d;
    end
  end

endmodule

// ===== design/nsfc_out_reg.sv =====
// Result register driving the outgoing stream.
// Depends on nsfc_pkg for the result word.
`timescale 1ns / 1ps

module nsfc_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  nsfc_pkg::nsfc_result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output nsfc_pkg::nsfc_result_t res_o
);
  import nsfc_pkg::*;

  logic         valid_q;
  nsfc_result_t res_q;

  // The register can take a new word if empty or emptied this cycle.
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== tb/nsfc_sentence_checker.sv =====
// Checker for the sentence framer: watches both stream channels, predicts result words.
// Compares every accepted result word field by field with the oldest prediction.
// Depends on nsfc_pkg.
`timescale 1ns / 1ps

module nsfc_sentence_checker
  import nsfc_pkg::*;
#(
  parameter int SentenceCap = SentenceCapDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          in_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Predicted sentence state.
  bit          in_frame   = 1'b0;
  bit          star_seen  = 1'b0;
  bit          hex_open   = 1'b0;
  logic [7:0]  char_count = '0;
  logic [7:0]  run_xor    = '0;
  logic [7:0]  hex_acc    = '0;
  logic [23:0] tag_chars  = '0;
  logic [15:0] good_total = '0;

  nsfc_result_t expected_q[$];
  int fails = 0;

  function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] v);
    bit ok;
    ok = 1'b1;
    v = '0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic clear_sentence();
    in_frame = 1'b0;
    star_seen = 1'b0;
    hex_open = 1'b0;
    char_count = '0;
    run_xor = '0;
    hex_acc = '0;
    tag_chars = '0;
  endtask

  task automatic take_byte(input logic [7:0] c);
    nsfc_result_t r;
    nsfc_type_e   ty;
    logic [3:0]   nib;
    bit           printable;
    printable = (c >= ChrSpace && c <= ChrTilde);
    if (!(printable || c == ChrCr || c == ChrLf)) begin
      // Control and high bytes vanish without a trace.
    end else if (c == ChrDollar) begin
      clear_sentence();
      in_frame = 1'b1;
      char_count = 8'd1;
    end else if (!in_frame) begin
      // Nothing is open, so the byte is ignored.
    end else if (c == ChrCr || c == ChrLf) begin
      ty = TY_OTHER;
      if (char_count >= 8'd6) begin
        if (tag_chars == TagGga) ty = TY_GGA;
        else if (tag_chars == TagRmc) ty = TY_RMC;
        else if (tag_chars == TagVtg) ty = TY_VTG;
        else if (tag_chars == TagGsa) ty = TY_GSA;
      end
      r = '0;
      r.sentence_type = ty;
      if (!star_seen) r.status = ST_NO_STAR;
      else if (run_xor != hex_acc) r.status = ST_BAD_SUM;
      else if (ty != TY_OTHER) r.status = ST_GOOD_KNOWN;
      else r.status = ST_GOOD_UNKNOWN;
      if (r.status == ST_GOOD_KNOWN) good_total = good_total + 16'd1;
      r.computed_sum = run_xor;
      r.received_sum = star_seen ? hex_acc : 8'd0;
      r.sentence_length = char_count[6:0];
      r.good_count = good_total;
      expected_q.push_back(r);
      clear_sentence();
    end else if (int'(char_count) >= SentenceCap - 1) begin
      // The sentence has grown too long and is thrown away without a result.
      clear_sentence();
    end else begin
      case (char_count)
        8'd3: tag_chars[23:16] = c;
        8'd4: tag_chars[15:8] = c;
        8'd5: tag_chars[7:0] = c;
        default: ;
      endcase
      if (!star_seen) begin
        if (c == ChrStar) begin
          star_seen = 1'b1;
          hex_open = 1'b1;
        end else begin
          run_xor = run_xor ^ c;
        end
      end else if (hex_open) begin
        if (decode_hex(c, nib)) hex_acc = {hex_acc[3:0], nib};
        else hex_open = 1'b0;
      end
      char_count = char_count + 8'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nsfc_result_t got;
    nsfc_result_t want;
    logic [OutDataW-ResultW-1:0] pad;
    if (!rst_ni) begin
      clear_sentence();
      good_total = '0;
      expected_q.delete();
    end else begin
      // The result side goes first: a word leaving now can never belong to a
      // terminator that enters at this same edge.
      if (out_valid_i && out_ready_i) begin
        got = nsfc_result_t'(out_data_i[ResultW-1:0]);
        pad = out_data_i[OutDataW-1:ResultW];
        if (expected_q.size() == 0) begin
          $error("result word 0x%h arrived with no sentence pending", out_data_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("sentence_type", 16'(want.sentence_type), 16'(got.sentence_type));
          check_field("computed_sum", 16'(want.computed_sum), 16'(got.computed_sum));
          check_field("received_sum", 16'(want.received_sum), 16'(got.received_sum));
          check_field("sentence_length", 16'(want.sentence_length),
                      16'(got.sentence_length));
          check_field("good_count", want.good_count, got.good_count);
          check_field("padding", 16'd0, 16'(pad));
        end
      end
      if (in_valid_i && in_ready_i) take_byte(in_byte_i);
    end
    fail_count_o <= fails;
    pending_o <= expected_q.size();
  end

endmodule

// ===== tb/tb_nmea_sentence_framer_checker_top.sv =====
// Testbench top for the sentence framer: clock, reset, byte stimulus and the verdict.
// Sentences are built with random content and sent with random gaps and back-pressure.
// Depends on nsfc_pkg, nsfc_sentence_checker and nmea_sentence_framer_checker_top.
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_checker_top;
  import nsfc_pkg::*;

  localparam int ByteTarget   = 700;
  localparam int LongHold     = 300;
  localparam logic [23:0] KnownTags [4] = '{TagGga, TagRmc, TagVtg, TagGsa};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int check_fails;
  int pending_words;

  bit quiet = 1'b0;      // both sides run without gaps while set
  bit long_hold = 1'b0;  // asks the result side for one long stall
  int sent_bytes = 0;
  logic [7:0] burst_q[$];
  logic [7:0] run_sum;

  always #5 clk_i = ~clk_i;

  nmea_sentence_framer_checker_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  nsfc_sentence_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (check_fails),
    .pending_o    (pending_words)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_upper();
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  // Printable, but never a start marker or an asterisk.
  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == ChrDollar || c == ChrStar);
    return c;
  endfunction

  function automatic logic [7:0] rand_dropped();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= ChrSpace && c <= ChrTilde) || c == ChrCr || c == ChrLf);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h57 : 8'h37) + n;
  endfunction

  task automatic put_body(input logic [7:0] c);
    burst_q.push_back(c);
    run_sum = run_sum ^ c;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_body(s[i]);
  endtask

  task automatic put_hex(input logic [7:0] v, input bit lower);
    burst_q.push_back(hex_char(v[7:4], lower));
    burst_q.push_back(hex_char(v[3:0], lower));
  endtask

  task automatic open_sentence();
    burst_q.push_back(ChrDollar);
    run_sum = '0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_burst();
    while (burst_q.size() > 0) begin
      if (!quiet && $urandom_range(0, 29) == 0) send_byte(rand_dropped());
      send_byte(burst_q.pop_front());
      sent_bytes++;
    end
  endtask

  // Stops offering words until every predicted result word has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic queue_sentence();
    int head;
    int body_len;
    int tail;
    int term;
    logic [23:0] tag;
    open_sentence();
    head = $urandom_range(0, 9);
    if (head < 8) begin
      put_body(rand_upper());
      put_body(rand_upper());
      if (head < 6) tag = KnownTags[$urandom_range(0, 3)];
      else tag = {rand_upper(), rand_upper(), rand_upper()};
      put_body(tag[23:16]);
      put_body(tag[15:8]);
      put_body(tag[7:0]);
    end else begin
      repeat ($urandom_range(0, 5)) put_body(rand_text());
    end
    // Now and then a body long enough to reach or pass the size limit.
    body_len = ($urandom_range(0, 24) == 0) ? $urandom_range(110, 135)
                                            : $urandom_range(0, 14);
    repeat (body_len) put_body(rand_text());

    tail = $urandom_range(0, 19);
    if (tail != 13 && tail != 14) burst_q.push_back(ChrStar);
    if (tail <= 10) begin
      put_hex(run_sum, $urandom_range(0, 2) == 0);
    end else if (tail <= 12) begin
      put_hex(run_sum ^ 8'($urandom_range(1, 255)), 1'b0);
    end else if (tail == 15) begin
      repeat ($urandom_range(3, 6))
        burst_q.push_back(hex_char(4'($urandom), $urandom_range(0, 1)));
    end else if (tail == 16) begin
      if ($urandom_range(0, 1)) burst_q.push_back(rand_text());
    end else if (tail == 17) begin
      // A second asterisk ends the digits and leaves the sums alone.
      put_hex(run_sum, 1'b0);
      burst_q.push_back(ChrStar);
      put_hex(8'($urandom), 1'b0);
    end else if (tail == 18) begin
      put_hex(run_sum, 1'b0);
      burst_q.push_back(8'($urandom_range(8'h47, 8'h5A)));
      put_hex(8'($urandom), 1'b1);
    end else if (tail == 19) begin
      burst_q.push_back(hex_char(4'($urandom), 1'b0));
    end

    term = $urandom_range(0, 9);
    if (term < 5) begin
      burst_q.push_back(ChrCr);
    end else if (term < 8) begin
      burst_q.push_back(ChrLf);
    end else if (term == 8) begin
      burst_q.push_back(ChrCr);
      burst_q.push_back(ChrLf);
    end
    // With no terminator the next start marker simply restarts the sentence.

    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) burst_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Result side: random stalls, plus one long stall on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                            : $urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes outside any sentence, a short sentence with no asterisk, a
    // good known sentence, a dropped byte inside a sentence with a bad sum,
    // and a good unknown one with lowercase digits.
    burst_q = '{8'h00, 8'hFF, ChrLf};
    open_sentence();
    put_text("AB");
    burst_q.push_back(ChrCr);
    open_sentence();
    put_text("GPGGA");
    burst_q.push_back(ChrStar);
    put_hex(run_sum, 1'b0);
    burst_q.push_back(ChrLf);
    open_sentence();
    put_body(ChrTilde);
    burst_q.push_back(8'h80);
    burst_q.push_back(ChrStar);
    burst_q.push_back("0");
    burst_q.push_back(ChrCr);
    open_sentence();
    put_text("Pz");
    burst_q.push_back(ChrStar);
    put_hex(run_sum, 1'b1);
    burst_q.push_back(ChrCr);
    send_burst();
    drain();

    n = 0;
    while (sent_bytes < ByteTarget) begin
      quiet = ((n / 10) % 5) == 3;
      if (n == 12 || n == 45) long_hold = 1'b1;
      queue_sentence();
      send_burst();
      n++;
      if (n % 20 == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (check_fails == 0) begin
      $display("[nmea_sentence_framer_checker_top] OK");
    end else begin
      $display("[nmea_sentence_framer_checker_top] ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every gap and stall at its longest.
  initial begin
    #5_000_000;
    $display("[nmea_sentence_framer_checker_top] ERROR");
    $finish;
  end

endmodule
